// ----- design/wsd_pkg.sv -----
// Shared types, constants and conversion functions for the WAV stream decoder.
// No dependencies; used by every other file in the design folder.
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

   localparam int OUT_BITS  = 24;
   localparam int FRAC_BITS = OUT_BITS - 1;
   localparam int FIFO_DEPTH = 4;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_HEADER    = 3'd1;
   localparam logic [2:0] ST_TRUNCATED = 3'd2;
   localparam logic [2:0] ST_BAD_FMT   = 3'd3;
   localparam logic [2:0] ST_MISSING   = 3'd4;
   localparam logic [2:0] ST_UNSUPP    = 3'd5;
   localparam logic [2:0] ST_LAYOUT    = 3'd6;
   localparam logic [2:0] ST_ORDER     = 3'd7;

   // four-character codes, little-endian as they arrive
   localparam logic [31:0] MAGIC_RIFF = 32'h4646_4952;
   localparam logic [31:0] MAGIC_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT    = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA   = 32'h6174_6164;
   localparam logic [31:0] GUID_TAIL  = 32'h0010_0000;

   localparam logic [15:0] FMT_PCM        = 16'h0001;
   localparam logic [15:0] FMT_FLOAT      = 16'h0003;
   localparam logic [15:0] FMT_EXTENSIBLE = 16'hFFFE;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_CHUNK,
      PH_PAYLOAD,
      PH_PAD,
      PH_HALT
   } phase_type;

   typedef struct packed {
      logic [7:0] file_byte;
      logic       end_of_file;
   } req_type;

   typedef struct packed {
      logic                        kind;
      logic signed [OUT_BITS-1:0]  sample_value;
      logic                        channel_index;
      logic [2:0]                  status;
      logic [31:0]                 sample_rate;
      logic [1:0]                  channel_count;
      logic                        run_last;
   } rsp_type;

   // up to two results produced by one byte
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   // (a + x) mod 3, x taken as four base-4 digits (4 = 1 mod 3)
   function automatic logic [1:0] mod3_add(input logic [1:0] a, input logic [7:0] x);
      logic [2:0] t;
      logic [1:0] r;
      r = a;
      for (int i = 0; i < 4; i++) begin
         t = {1'b0, r} + {1'b0, x[2*i +: 2]};
         if (t >= 3'd3) begin
            t = t - 3'd3;
         end
         r = t[1:0];
      end
      return r;
   endfunction

   // float32 to Q1.FRAC_BITS, truncated toward zero, saturating
   function automatic logic [OUT_BITS-1:0] float_to_q(input logic [31:0] v);
      logic [7:0]              e;
      logic [7:0]              sh;
      logic [23+FRAC_BITS:0]   wide;
      logic [OUT_BITS-1:0]     mag;
      e = v[30:23];
      sh = 8'd150 - e;
      wide = {1'b1, v[22:0], {FRAC_BITS{1'b0}}} >> sh;
      mag = wide[OUT_BITS-1:0];
      if (e == 8'hFF || e == 8'h00) begin
         return '0;
      end else if (e >= 8'd127) begin
         return v[31] ? {1'b1, {FRAC_BITS{1'b0}}} : {1'b0, {FRAC_BITS{1'b1}}};
      end else begin
         return v[31] ? (~mag + 1'b1) : mag;
      end
   endfunction

endpackage

`default_nettype wire

// ----- design/wsd_parser.sv -----
// Byte-level RIFF/WAVE parser: header check, chunk walk, fmt capture, sample
// conversion and the end-of-file report. Depends on wsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsd_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_take,
   input  wire wsd_pkg::req_type  in_item,
   output wsd_pkg::push_type      push
);

   localparam int PCM_SHIFT = 32 - wsd_pkg::OUT_BITS;

   wsd_pkg::phase_type phase_ff, phase_in;
   logic [5:0]  pos_ff, pos_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] rem_ff, rem_in;
   logic [1:0]  rem3_ff, rem3_in;
   logic        pad_ff, pad_in;
   logic [15:0] fmt_ff, fmt_in;
   logic [15:0] chan_ff, chan_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] align_ff, align_in;
   logic [15:0] bits_ff, bits_in;
   logic [15:0] vbits_ff, vbits_in;
   logic [15:0] subfmt_ff, subfmt_in;
   logic [31:0] asm_ff, asm_in;
   logic [1:0]  sbyte_ff, sbyte_in;
   logic        chidx_ff, chidx_in;
   logic        have_fmt_ff, have_fmt_in;
   logic        have_data_ff, have_data_in;
   logic [2:0]  err_ff, err_in;

   logic [7:0]  b;
   logic [5:0]  pos_inc;
   logic [2:0]  bps;
   logic [31:0] word;
   logic [31:0] s32;
   logic [31:0] pcm_wide;
   logic [wsd_pkg::OUT_BITS-1:0] sample_q;
   logic        is_last;
   logic        mod_ok;
   logic        ext;
   logic [15:0] code;
   logic [15:0] align_want;
   logic        emit;
   logic [2:0]  st;
   wsd_pkg::rsp_type smp_r;
   wsd_pkg::rsp_type rep_r;

   assign b       = in_item.file_byte;
   assign pos_inc = (pos_ff == 6'h3F) ? pos_ff : pos_ff + 6'd1;
   assign bps     = bits_ff[5:3];
   assign word    = asm_ff | ({24'b0, b} << {sbyte_ff, 3'b000});
   assign is_last = ({1'b0, sbyte_ff} == bps - 3'd1);
   assign ext     = (fmt_ff == wsd_pkg::FMT_EXTENSIBLE);

   // left-align the sample at bit 31; 8-bit data is offset binary
   always_comb begin
      unique case (bps)
         3'd1:    s32 = {word[7] ^ 1'b1, word[6:0], 24'b0};
         3'd2:    s32 = {word[15:0], 16'b0};
         3'd3:    s32 = {word[23:0], 8'b0};
         default: s32 = word;
      endcase
   end

   assign pcm_wide = $unsigned($signed(s32) >>> PCM_SHIFT);
   assign sample_q = (fmt_ff == wsd_pkg::FMT_FLOAT) ? wsd_pkg::float_to_q(word)
                                                   : pcm_wide[wsd_pkg::OUT_BITS-1:0];

   // data size must be a multiple of block align (1,2,3,4,6 or 8)
   always_comb begin
      unique case (align_ff)
         16'd1:   mod_ok = 1'b1;
         16'd2:   mod_ok = ~rem_in[0];
         16'd3:   mod_ok = (rem3_in == 2'd0);
         16'd4:   mod_ok = (rem_in[1:0] == 2'd0);
         16'd6:   mod_ok = ~rem_in[0] && (rem3_in == 2'd0);
         16'd8:   mod_ok = (rem_in[2:0] == 3'd0);
         default: mod_ok = 1'b0;
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      pos_in = pos_ff;
      tag_in = tag_ff;
      rem_in = rem_ff;
      rem3_in = rem3_ff;
      pad_in = pad_ff;
      fmt_in = fmt_ff;
      chan_in = chan_ff;
      rate_in = rate_ff;
      align_in = align_ff;
      bits_in = bits_ff;
      vbits_in = vbits_ff;
      subfmt_in = subfmt_ff;
      asm_in = asm_ff;
      sbyte_in = sbyte_ff;
      chidx_in = chidx_ff;
      have_fmt_in = have_fmt_ff;
      have_data_in = have_data_ff;
      err_in = err_ff;
      emit = 1'b0;
      code = fmt_ff;
      align_want = '0;

      unique case (phase_ff)
         wsd_pkg::PH_HEADER: begin
            if ((pos_ff < 6'd4 && b != wsd_pkg::MAGIC_RIFF[{pos_ff[1:0], 3'b000} +: 8]) ||
                (pos_ff >= 6'd8 && pos_ff < 6'd12 &&
                 b != wsd_pkg::MAGIC_WAVE[{pos_ff[1:0], 3'b000} +: 8])) begin
               err_in = wsd_pkg::ST_HEADER;
               phase_in = wsd_pkg::PH_HALT;
            end else if (pos_ff == 6'd11) begin
               phase_in = wsd_pkg::PH_CHUNK;
               pos_in = '0;
            end else begin
               pos_in = pos_inc;
            end
         end

         wsd_pkg::PH_CHUNK: begin
            if (pos_ff < 6'd4) begin
               if (pos_ff == 6'd0) begin
                  tag_in = '0;
               end
               tag_in[{pos_ff[1:0], 3'b000} +: 8] = b;
            end else begin
               if (pos_ff == 6'd4) begin
                  rem_in = '0;
               end
               rem_in[{pos_ff[1:0], 3'b000} +: 8] = b;
               rem3_in = wsd_pkg::mod3_add((pos_ff == 6'd4) ? 2'd0 : rem3_ff, b);
            end
            pos_in = pos_inc;
            if (pos_ff == 6'd7) begin
               pos_in = '0;
               pad_in = rem_in[0];
               if (tag_in == wsd_pkg::TAG_FMT) begin
                  if (have_fmt_ff || have_data_ff) begin
                     err_in = wsd_pkg::ST_ORDER;
                     phase_in = wsd_pkg::PH_HALT;
                  end else if (rem_in < 32'd16) begin
                     err_in = wsd_pkg::ST_BAD_FMT;
                     phase_in = wsd_pkg::PH_HALT;
                  end else begin
                     fmt_in = '0;
                     chan_in = '0;
                     rate_in = '0;
                     align_in = '0;
                     bits_in = '0;
                     vbits_in = '0;
                     subfmt_in = '0;
                     phase_in = wsd_pkg::PH_PAYLOAD;
                  end
               end else if (tag_in == wsd_pkg::TAG_DATA) begin
                  if (!have_fmt_ff || have_data_ff) begin
                     err_in = wsd_pkg::ST_ORDER;
                     phase_in = wsd_pkg::PH_HALT;
                  end else if (rem_in == 32'd0 || !mod_ok) begin
                     err_in = wsd_pkg::ST_LAYOUT;
                     phase_in = wsd_pkg::PH_HALT;
                  end else begin
                     have_data_in = 1'b1;
                     sbyte_in = '0;
                     chidx_in = 1'b0;
                     asm_in = '0;
                     phase_in = wsd_pkg::PH_PAYLOAD;
                  end
               end else if (rem_in == 32'd0) begin
                  // empty unknown chunk: nothing to skip
                  phase_in = wsd_pkg::PH_CHUNK;
               end else begin
                  phase_in = wsd_pkg::PH_PAYLOAD;
               end
            end
         end

         wsd_pkg::PH_PAYLOAD: begin
            if (tag_ff == wsd_pkg::TAG_FMT) begin
               priority if (pos_ff < 6'd2) begin
                  fmt_in[{pos_ff[0], 3'b000} +: 8] = b;
               end else if (pos_ff < 6'd4) begin
                  chan_in[{pos_ff[0], 3'b000} +: 8] = b;
               end else if (pos_ff < 6'd8) begin
                  rate_in[{pos_ff[1:0], 3'b000} +: 8] = b;
               end else if (pos_ff == 6'd12 || pos_ff == 6'd13) begin
                  align_in[{pos_ff[0], 3'b000} +: 8] = b;
               end else if (pos_ff == 6'd14 || pos_ff == 6'd15) begin
                  bits_in[{pos_ff[0], 3'b000} +: 8] = b;
               end else if ((pos_ff == 6'd18 || pos_ff == 6'd19) && ext) begin
                  vbits_in[{pos_ff[0], 3'b000} +: 8] = b;
               end else if ((pos_ff == 6'd24 || pos_ff == 6'd25) && ext) begin
                  subfmt_in[{pos_ff[0], 3'b000} +: 8] = b;
               end else if (pos_ff >= 6'd28 && pos_ff < 6'd32 && ext && b != 8'd0) begin
                  err_in = wsd_pkg::ST_BAD_FMT;
                  phase_in = wsd_pkg::PH_HALT;
               end else if (pos_ff >= 6'd32 && pos_ff < 6'd36 && ext &&
                            b != wsd_pkg::GUID_TAIL[{pos_ff[1:0], 3'b000} +: 8]) begin
                  err_in = wsd_pkg::ST_BAD_FMT;
                  phase_in = wsd_pkg::PH_HALT;
               end else begin
                  fmt_in = fmt_ff;
               end
            end else if (tag_ff == wsd_pkg::TAG_DATA) begin
               if (is_last) begin
                  emit = 1'b1;
                  asm_in = '0;
                  sbyte_in = '0;
                  chidx_in = (chan_ff == 16'd2) ? ~chidx_ff : 1'b0;
               end else begin
                  asm_in = word;
                  sbyte_in = sbyte_ff + 2'd1;
               end
            end

            if (err_in == wsd_pkg::ST_OK) begin
               pos_in = pos_inc;
               rem_in = rem_ff - 32'd1;
               if (rem_ff == 32'd1) begin
                  if (tag_ff == wsd_pkg::TAG_FMT) begin
                     code = (fmt_in == wsd_pkg::FMT_EXTENSIBLE) ? subfmt_in : fmt_in;
                     align_want = (chan_in == 16'd1) ? {3'b0, bits_in[15:3]}
                                                     : {2'b0, bits_in[15:3], 1'b0};
                     if (fmt_in == wsd_pkg::FMT_EXTENSIBLE && pos_in < 6'd40) begin
                        err_in = wsd_pkg::ST_BAD_FMT;
                     end else if ((code != wsd_pkg::FMT_PCM && code != wsd_pkg::FMT_FLOAT) ||
                                  (chan_in != 16'd1 && chan_in != 16'd2) ||
                                  rate_in == 32'd0 ||
                                  (code == wsd_pkg::FMT_FLOAT && bits_in != 16'd32) ||
                                  (code == wsd_pkg::FMT_PCM && bits_in != 16'd8 &&
                                   bits_in != 16'd16 && bits_in != 16'd24 &&
                                   bits_in != 16'd32)) begin
                        err_in = wsd_pkg::ST_UNSUPP;
                        fmt_in = code;
                     end else if (align_in != align_want ||
                                  (code == wsd_pkg::FMT_PCM && vbits_in > bits_in)) begin
                        err_in = wsd_pkg::ST_LAYOUT;
                        fmt_in = code;
                     end else begin
                        fmt_in = code;
                        have_fmt_in = 1'b1;
                     end
                  end
                  if (err_in == wsd_pkg::ST_OK) begin
                     phase_in = pad_ff ? wsd_pkg::PH_PAD : wsd_pkg::PH_CHUNK;
                     pos_in = '0;
                  end else begin
                     phase_in = wsd_pkg::PH_HALT;
                  end
               end
            end
         end

         wsd_pkg::PH_PAD: begin
            pad_in = 1'b0;
            phase_in = wsd_pkg::PH_CHUNK;
            pos_in = '0;
         end

         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   // end-of-file status, judged on the state after this byte
   always_comb begin
      if (err_in != wsd_pkg::ST_OK) begin
         st = err_in;
      end else if (phase_in == wsd_pkg::PH_HEADER) begin
         st = wsd_pkg::ST_HEADER;
      end else if (phase_in == wsd_pkg::PH_PAYLOAD || phase_in == wsd_pkg::PH_PAD) begin
         st = wsd_pkg::ST_TRUNCATED;
      end else if (!have_fmt_in || !have_data_in) begin
         st = wsd_pkg::ST_MISSING;
      end else begin
         st = wsd_pkg::ST_OK;
      end
   end

   always_comb begin
      smp_r = '0;
      smp_r.kind = 1'b0;
      smp_r.sample_value = sample_q;
      smp_r.channel_index = chidx_ff;
      smp_r.status = wsd_pkg::ST_OK;
      smp_r.sample_rate = rate_ff;
      smp_r.channel_count = chan_ff[1:0];
      smp_r.run_last = ~in_item.end_of_file;

      rep_r = '0;
      rep_r.kind = 1'b1;
      rep_r.status = st;
      rep_r.sample_rate = have_fmt_in ? rate_in : 32'd0;
      rep_r.channel_count = have_fmt_in ? chan_in[1:0] : 2'd0;
      rep_r.run_last = 1'b1;

      push = '0;
      if (in_take) begin
         if (emit && in_item.end_of_file) begin
            push.count = 2'd2;
            push.first = smp_r;
            push.second = rep_r;
         end else if (emit) begin
            push.count = 2'd1;
            push.first = smp_r;
         end else if (in_item.end_of_file) begin
            push.count = 2'd1;
            push.first = rep_r;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (in_take && in_item.end_of_file)) begin
         phase_ff <= wsd_pkg::PH_HEADER;
         pos_ff <= '0;
         tag_ff <= '0;
         rem_ff <= '0;
         rem3_ff <= '0;
         pad_ff <= 1'b0;
         fmt_ff <= '0;
         chan_ff <= '0;
         rate_ff <= '0;
         align_ff <= '0;
         bits_ff <= '0;
         vbits_ff <= '0;
         subfmt_ff <= '0;
         asm_ff <= '0;
         sbyte_ff <= '0;
         chidx_ff <= 1'b0;
         have_fmt_ff <= 1'b0;
         have_data_ff <= 1'b0;
         err_ff <= wsd_pkg::ST_OK;
      end else if (in_take) begin
         phase_ff <= phase_in;
         pos_ff <= pos_in;
         tag_ff <= tag_in;
         rem_ff <= rem_in;
         rem3_ff <= rem3_in;
         pad_ff <= pad_in;
         fmt_ff <= fmt_in;
         chan_ff <= chan_in;
         rate_ff <= rate_in;
         align_ff <= align_in;
         bits_ff <= bits_in;
         vbits_ff <= vbits_in;
         subfmt_ff <= subfmt_in;
         asm_ff <= asm_in;
         sbyte_ff <= sbyte_in;
         chidx_ff <= chidx_in;
         have_fmt_ff <= have_fmt_in;
         have_data_ff <= have_data_in;
         err_ff <= err_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/wsd_out_fifo.sv -----
// Result queue: takes up to two results per cycle, hands out one.
// Depends on wsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsd_out_fifo (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire wsd_pkg::push_type  push,
   output logic                    space_ok,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output wsd_pkg::rsp_type        rsp_data
);

   localparam int PW = $clog2(wsd_pkg::FIFO_DEPTH);

   wsd_pkg::rsp_type mem [wsd_pkg::FIFO_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   cnt_ff, cnt_in;
   logic [PW-1:0] wr_next;
   logic          pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (cnt_ff != '0);
   assign rsp_data  = mem[rd_ptr_ff];
   assign space_ok  = (cnt_ff <= (PW+1)'(wsd_pkg::FIFO_DEPTH - 2));
   assign wr_next   = wr_ptr_ff + PW'(1);
   assign wr_ptr_in = wr_ptr_ff + PW'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PW'(pop);
   assign cnt_in    = cnt_ff + (PW+1)'(push.count) - (PW+1)'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (PW+1)'(wsd_pkg::FIFO_DEPTH))
      else $error("result queue over capacity");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      PW'(wr_ptr_ff - rd_ptr_ff) == cnt_ff[PW-1:0])
      else $error("queue pointers disagree with count");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> space_ok)
      else $error("push into a queue without room");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      (pop && push.count == 2'd0) |=> cnt_ff == $past(cnt_ff) - (PW+1)'(1))
      else $error("count not decremented on pop");

endmodule

`default_nettype wire

// ----- design/wav_stream_decoder_top.sv -----
// Top level of the WAV stream decoder: parser plus result queue.
// Depends on wsd_pkg, wsd_parser and wsd_out_fifo.
//
//   channel  | ports                          | item
//   ---------+--------------------------------+-------------------------------
//   request  | req_valid req_ready req_data   | one file byte + end flag
//   response | rsp_valid rsp_ready rsp_data   | sample or final status report
//
// One byte is taken per cycle while req_ready is high; its results enter the
// queue at the accepting edge and show on rsp once earlier results have drained.
// A byte yields zero, one or two results; the queue drains one per cycle while rsp_ready is high.
// req_ready drops only when the 4-entry result queue cannot take two more.
// Reset clears the parser to the header phase and empties the queue.
// The byte that carries the end flag also returns the parser to reset state.
`timescale 1ns / 1ps
`default_nettype none

module wav_stream_decoder_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire wsd_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output wsd_pkg::rsp_type       rsp_data
);

   wsd_pkg::push_type push;
   logic              take;

   assign take = req_valid && req_ready;

   wsd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .in_take (take),
      .in_item (req_data),
      .push    (push)
   );

   wsd_out_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
